// ===== hw/rtl/lcd_progress_bar_cells_macros.svh =====
// Assertion macros used by the progress bar controller RTL.
// Each one is clocked on clk_i and is switched off while rst_ni is low.
`ifndef LCD_PROGRESS_BAR_CELLS_MACROS_SVH
`define LCD_PROGRESS_BAR_CELLS_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LPBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define LPBC_NEVER(label, expr, msg) \
  `LPBC_ASSERT(label, !(expr), msg)

`endif

// ===== hw/rtl/lpbc_pkg.sv =====
`default_nettype none

package lpbc_pkg;

  // Fixed field widths.
  localparam int ProgW = 8;
  localparam int MaxW  = 8;
  localparam int LenW  = 6;
  localparam int CodeW = 3;
  localparam int IdxW  = 6;
  localparam int CfgW  = 8;
  localparam int CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxProgress = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBarLength   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [MaxW-1:0] MaxProgressRst = 8'd255;
  localparam logic [LenW-1:0] BarLengthRst   = 6'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the product and start a new run
    logic div_step;   // one restoring division step
    logic next_cell;  // move to the next cell of the bar
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;   // current cell is the final one
    logic empty;  // bar has no cells at all
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpbc_dpath.sv =====
`default_nettype none

module lpbc_dpath #(
  parameter int PIXELS_PER_CELL = 5,
  parameter int MAX_BAR_CELLS   = 40,
  parameter int DIV_STEPS       = 17
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [lpbc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [lpbc_pkg::CfgW-1:0]           cfg_data_i,
  input  wire  [lpbc_pkg::ProgW-1:0]          progress_i,
  input  wire  lpbc_pkg::cmd_t                cmd_i,
  output lpbc_pkg::sts_t                      sts_o,
  output logic [lpbc_pkg::CodeW-1:0]          cell_code_o,
  output logic [lpbc_pkg::IdxW-1:0]           cell_index_o
);
  import lpbc_pkg::*;

  localparam int PpcW      = $clog2(PIXELS_PER_CELL + 1);
  localparam int LenPpcW   = LenW + PpcW;
  localparam int LoW       = $clog2(MAX_BAR_CELLS * PIXELS_PER_CELL + 1);
  localparam int CellsRstI = (16 > MAX_BAR_CELLS) ? MAX_BAR_CELLS : 16;

  // Configuration: the raw maximum, the saturated cell count and the raw
  // length times pixels per cell.
  logic [MaxW-1:0]    max_q, max_d;
  logic [LenW-1:0]    cells_q, cells_d;
  logic [LenPpcW-1:0] lenppc_q, lenppc_d;

  // Division: quotient shifts in where the dividend shifts out.
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic [MaxW-1:0]      rem_q, rem_d;

  // Cell walk: first pixel of the current cell and its index.
  logic [LoW-1:0]  lo_q, lo_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [LenW-1:0]      len_w;
  logic [MaxW-1:0]      divisor;
  logic [MaxW:0]        rem_sh;
  logic                 rem_ge;
  logic [LoW-1:0]       hi;
  logic [DIV_STEPS-1:0] lo_ext, hi_ext, part;

  always_comb begin
    max_d    = max_q;
    cells_d  = cells_q;
    lenppc_d = lenppc_q;
    len_w    = cfg_data_i[LenW-1:0];
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMaxProgress: max_d = cfg_data_i[MaxW-1:0];
        CfgBarLength: begin
          lenppc_d = LenPpcW'(len_w) * LenPpcW'(PIXELS_PER_CELL);
          if ({1'b0, len_w} > (LenW + 1)'(MAX_BAR_CELLS)) begin
            cells_d = LenW'(MAX_BAR_CELLS);
          end else begin
            cells_d = len_w;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MaxProgressRst;
      cells_q  <= LenW'(CellsRstI);
      lenppc_q <= LenPpcW'(BarLengthRst) * LenPpcW'(PIXELS_PER_CELL);
    end else begin
      max_q    <= max_d;
      cells_q  <= cells_d;
      lenppc_q <= lenppc_d;
    end
  end

  // A zero maximum divides as one.
  assign divisor = (max_q == '0) ? MaxW'(1) : max_q;
  assign rem_sh  = {rem_q, quo_q[DIV_STEPS-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    lo_d  = lo_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      quo_d = DIV_STEPS'(progress_i) * DIV_STEPS'(lenppc_q);
      rem_d = '0;
      lo_d  = '0;
      idx_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? MaxW'(rem_sh - {1'b0, divisor}) : rem_sh[MaxW-1:0];
      quo_d = {quo_q[DIV_STEPS-2:0], rem_ge};
    end else if (cmd_i.next_cell) begin
      lo_d  = lo_q + LoW'(PIXELS_PER_CELL);
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    idx_q <= idx_d;
  end

  // After the division the quotient is the filled pixel count.
  assign hi     = lo_q + LoW'(PIXELS_PER_CELL);
  assign lo_ext = DIV_STEPS'(lo_q);
  assign hi_ext = DIV_STEPS'(hi);
  assign part   = quo_q - lo_ext;

  always_comb begin
    if (hi_ext <= quo_q) begin
      cell_code_o = CodeW'(PIXELS_PER_CELL);
    end else if (lo_ext > quo_q) begin
      cell_code_o = '0;
    end else begin
      cell_code_o = part[CodeW-1:0];
    end
  end

  assign cell_index_o = idx_q;
  assign sts_o.last   = ({1'b0, idx_q} + (IdxW + 1)'(1)) == {1'b0, cells_q};
  assign sts_o.empty  = cells_q == '0;

endmodule

`default_nettype wire

// ===== hw/rtl/lpbc_ctrl.sv =====
`default_nettype none
`include "lcd_progress_bar_cells_macros.svh"

module lpbc_ctrl #(
  parameter int DIV_STEPS = 17
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  wire  lpbc_pkg::sts_t sts_i,
  output lpbc_pkg::cmd_t   cmd_o
);
  import lpbc_pkg::*;

  localparam int StepW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             in_xfer, out_xfer, step_last;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_o && out_ready_i;
  assign step_last = step_q == StepW'(DIV_STEPS - 1);

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StEmit;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o          = '0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_last) begin
          state_d = sts_i.empty ? StIdle : StEmit;
        end
      end
      StEmit: begin
        if (out_xfer) begin
          if (sts_i.last) begin
            state_d = StIdle;
          end else begin
            cmd_o.next_cell = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `LPBC_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input taken while emitting cells")
  `LPBC_ASSERT(a_busy_after_in, in_xfer |=> !in_ready_o, "ready right after an input transfer")
  `LPBC_ASSERT(a_idle_after_last, (out_xfer && sts_i.last) |=> in_ready_o, "no idle after last cell")
  `LPBC_ASSERT(a_step_bound, (state_q == StDiv) |-> (step_q <= StepW'(DIV_STEPS - 1)), "division overran")

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_progress_bar_cells.sv =====
// Character-LCD progress bar coder. Each progress value taken on the input
// channel becomes a run of glyph codes, one transfer per character cell of
// the bar, starting at cell 0 and flagged on the final cell. The filled pixel
// count is progress * bar_length * PIXELS_PER_CELL / max_progress, computed
// exactly and truncated; a maximum of zero divides as one, a length above
// MAX_BAR_CELLS is cut to MAX_BAR_CELLS cells, and a length of zero gives no
// cells. Codes are 0 for an empty cell, the pixel count for a partial cell
// and PIXELS_PER_CELL (masked to three bits) for a full one. After the input
// transfer loads the product, a restoring divider takes one quotient bit per
// cycle, then the cells go out one per cycle while the output side keeps
// ready high. Only one progress value is in flight at a time. The
// configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them only while the block is idle, since
// the block itself does not enforce it.
`default_nettype none

module lcd_progress_bar_cells #(
  parameter int PIXELS_PER_CELL = 5,
  parameter int MAX_BAR_CELLS   = 40
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write port: 0 is max_progress, 1 is bar_length.
  input  wire                              cfg_we_i,
  input  wire  [lpbc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [lpbc_pkg::CfgW-1:0]        cfg_data_i,
  // Progress input channel.
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [lpbc_pkg::ProgW-1:0]       progress_i,
  // Cell output channel.
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [lpbc_pkg::CodeW-1:0]       cell_code_o,
  output logic [lpbc_pkg::IdxW-1:0]        cell_index_o,
  output logic                             last_cell_o
);
  import lpbc_pkg::*;

  // The dividend holds progress times length times pixels per cell, and the
  // divider walks one bit of it per cycle.
  localparam int DivSteps = ProgW + LenW + $clog2(PIXELS_PER_CELL + 1);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences load, division and the cell walk.
  lpbc_ctrl #(
    .DIV_STEPS (DivSteps)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the divider and the cell counters.
  lpbc_dpath #(
    .PIXELS_PER_CELL (PIXELS_PER_CELL),
    .MAX_BAR_CELLS   (MAX_BAR_CELLS),
    .DIV_STEPS       (DivSteps)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .progress_i   (progress_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cell_code_o  (cell_code_o),
    .cell_index_o (cell_index_o)
  );

  // The last flag comes straight from the cell counter compare.
  assign last_cell_o = sts.last;

endmodule

`default_nettype wire
